/* rtl/cnv3_pkg.sv */
// cnv3_pkg: shared constants, register codes and structs for the 3x3 convolution block.
// Depends on nothing; every other file of the block imports it.

package cnv3_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DEF_MAX_WIDTH   = 128;
    localparam int DEF_MAX_HEIGHT  = 128;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int KERNEL     = 3;
    localparam int DIM_W      = 8;     // image_width / image_height register width
    localparam int WEIGHT_W   = 16;    // one Q8.8 kernel weight
    localparam int WROW_W     = KERNEL * WEIGHT_W;
    localparam int BIAS_W     = 32;
    localparam int ACC_W      = 40;    // accumulator word
    localparam int RES_W      = 32;    // emitted result
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WROW_W;

    // Output queue; also bounds the number of words in flight
    localparam int FIFO_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_WEIGHTS_TOP,
        REG_WEIGHTS_MIDDLE,
        REG_WEIGHTS_BOTTOM,
        REG_BIAS_VALUE,
        REG_FIRST_CHANNEL,
        REG_LAST_CHANNEL
    } t_cfg_reg;

    typedef struct packed {
        logic [DIM_W-1:0]         image_width;
        logic [DIM_W-1:0]         image_height;
        logic [WROW_W-1:0]        weights_top;
        logic [WROW_W-1:0]        weights_middle;
        logic [WROW_W-1:0]        weights_bottom;
        logic signed [BIAS_W-1:0] bias_value;
        logic                     first_channel;
        logic                     last_channel;
    } t_cfg;

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic vld;       // stage holds a word
        logic emit;      // word completes an interior neighborhood
        logic last_px;   // last interior pixel of the plane
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic                    plane_done;
    } t_result;

    // Kernel weight at (row, col); left column sits in the low bits of a row
    function automatic logic signed [WEIGHT_W-1:0] weight_at(input t_cfg cfg,
                                                             input int unsigned krow,
                                                             input int unsigned kcol);
        logic [WROW_W-1:0] wrow;
        case (krow)
            0:       wrow = cfg.weights_top;
            1:       wrow = cfg.weights_middle;
            default: wrow = cfg.weights_bottom;
        endcase
        return $signed(wrow[WEIGHT_W*kcol +: WEIGHT_W]);
    endfunction

endpackage

/* rtl/cnv3_chan_if.sv */
// cnv3 channel interfaces: sample input, result output and register write channel.
// Depends on cnv3_pkg for widths.

interface cnv3_sample_if #(
    parameter int SAMPLE_BITS = cnv3_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface cnv3_result_if;
    import cnv3_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic                    plane_done;

    modport source (output valid, output result_value, output plane_done, input ready);
    modport sink   (input valid, input result_value, input plane_done, output ready);
endinterface

interface cnv3_cfg_if;
    import cnv3_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/cnv3_cfg_regs.sv */
// cnv3_cfg_regs: register file written through the configuration channel.
// Depends on cnv3_pkg and cnv3_cfg_if.

module cnv3_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cnv3_cfg_if.sink          i_cfg_ch,
    output cnv3_pkg::t_cfg    o_cfg
);
    import cnv3_pkg::*;

    t_cfg r_cfg;

    assign i_cfg_ch.ready = 1'b1;
    assign o_cfg          = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= DIM_W'(DEF_MAX_WIDTH);
            r_cfg.image_height   <= DIM_W'(DEF_MAX_HEIGHT);
            r_cfg.weights_top    <= '0;
            r_cfg.weights_middle <= '0;
            r_cfg.weights_bottom <= '0;
            r_cfg.bias_value     <= '0;
            r_cfg.first_channel  <= 1'b1;
            r_cfg.last_channel   <= 1'b1;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                REG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_ch.data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_ch.data[DIM_W-1:0];
                REG_WEIGHTS_TOP:    r_cfg.weights_top    <= i_cfg_ch.data[WROW_W-1:0];
                REG_WEIGHTS_MIDDLE: r_cfg.weights_middle <= i_cfg_ch.data[WROW_W-1:0];
                REG_WEIGHTS_BOTTOM: r_cfg.weights_bottom <= i_cfg_ch.data[WROW_W-1:0];
                REG_BIAS_VALUE:     r_cfg.bias_value     <= $signed(i_cfg_ch.data[BIAS_W-1:0]);
                REG_FIRST_CHANNEL:  r_cfg.first_channel  <= i_cfg_ch.data[0];
                REG_LAST_CHANNEL:   r_cfg.last_channel   <= i_cfg_ch.data[0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/cnv3_window.sv */
// cnv3_window: raster position counters, two-row line store and the 3x3 sample window.
// Depends on cnv3_pkg.

module cnv3_window #(
    parameter int MAX_WIDTH   = cnv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = cnv3_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = cnv3_pkg::DEF_SAMPLE_BITS,
    parameter int AW          = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cnv3_pkg::t_cfg                i_cfg,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output cnv3_pkg::t_pipe_ctl           o_ctl,
    output logic [AW-1:0]                 o_idx,
    output logic signed [SAMPLE_BITS-1:0] o_win [cnv3_pkg::KERNEL*cnv3_pkg::KERNEL]
);
    import cnv3_pkg::*;

    localparam int KK       = KERNEL * KERNEL;
    localparam int LINE_LEN = MAX_WIDTH + 2;
    localparam int LAW      = $clog2(LINE_LEN);
    localparam int CW       = $clog2(MAX_WIDTH + 3);
    localparam int RW       = $clog2(MAX_HEIGHT + 3);
    localparam int CMW      = (CW > DIM_W) ? CW : DIM_W;
    localparam int RMW      = (RW > DIM_W) ? RW : DIM_W;

    // effective sizes and padded bounds
    logic [CMW-1:0] w_eff, w_bound;
    logic [RMW-1:0] h_eff, h_bound;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff = CMW'(1);
        end else if (CMW'(i_cfg.image_width) > CMW'(MAX_WIDTH)) begin
            w_eff = CMW'(MAX_WIDTH);
        end else begin
            w_eff = CMW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h_eff = RMW'(1);
        end else if (RMW'(i_cfg.image_height) > RMW'(MAX_HEIGHT)) begin
            h_eff = RMW'(MAX_HEIGHT);
        end else begin
            h_eff = RMW'(i_cfg.image_height);
        end
        w_bound = w_eff + CMW'(2);
        h_bound = h_eff + RMW'(2);
    end

    // position counters
    logic [CW-1:0] r_col, n_col, cur_col;
    logic [RW-1:0] r_row, n_row, cur_row;

    always_comb begin
        cur_col = (CMW'(r_col) >= w_bound) ? '0 : r_col;
        cur_row = (RMW'(r_row) >= h_bound) ? '0 : r_row;
        n_col   = r_col;
        n_row   = r_row;
        if (i_accept) begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
            if (CMW'(n_col) >= w_bound) begin
                n_col = '0;
                n_row = cur_row + RW'(1);
                if (RMW'(n_row) >= h_bound) begin
                    n_row = '0;
                end
            end
        end
    end

    // stage 1: line store read issued at accept
    logic                          r_s1_vld;
    logic [CW-1:0]                 r_s1_col;
    logic [RW-1:0]                 r_s1_row;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;

    // line store word: upper half = older row, lower half = newer row
    logic [2*SAMPLE_BITS-1:0] r_line [LINE_LEN];
    logic [2*SAMPLE_BITS-1:0] r_line_rd;
    logic [LINE_LEN-1:0]      r_line_vld;
    logic                     r_rd_vld;

    logic signed [SAMPLE_BITS-1:0] line_top, line_mid;

    // an entry never written reads as zero
    assign line_top = r_rd_vld ? $signed(r_line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
    assign line_mid = r_rd_vld ? $signed(r_line_rd[SAMPLE_BITS-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_line_rd <= r_line[cur_col[LAW-1:0]];
        end
        if (r_s1_vld) begin
            r_line[r_s1_col[LAW-1:0]] <= {line_mid, r_s1_sample};
        end
    end

    // window shift: oldest column drops out, new column enters on the right
    logic signed [SAMPLE_BITS-1:0] r_win [KK];
    logic signed [SAMPLE_BITS-1:0] n_win [KK];

    always_comb begin
        for (int r = 0; r < KERNEL; r++) begin
            for (int c = 0; c < KERNEL - 1; c++) begin
                n_win[r*KERNEL + c] = r_win[r*KERNEL + c + 1];
            end
        end
        n_win[KERNEL - 1]     = line_top;
        n_win[2*KERNEL - 1]   = line_mid;
        n_win[KK - 1]         = r_s1_sample;
    end

    // stage 2 control and accumulator address
    t_pipe_ctl     r_s2_ctl, n_s2_ctl;
    logic [AW-1:0] r_s2_idx, n_s2_idx;

    always_comb begin
        n_s2_ctl.vld     = r_s1_vld;
        n_s2_ctl.emit    = r_s1_vld && (r_s1_row >= RW'(2)) && (r_s1_col >= CW'(2));
        n_s2_ctl.last_px = n_s2_ctl.emit && (RMW'(r_s1_row) == h_eff + RMW'(1))
                           && (CMW'(r_s1_col) == w_eff + CMW'(1));
        n_s2_idx = AW'(r_s1_row - RW'(2)) * AW'(MAX_WIDTH) + AW'(r_s1_col - CW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_vld   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_line_vld <= '0;
            r_s2_ctl   <= '0;
            for (int k = 0; k < KK; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1_vld <= i_accept;
            r_s2_ctl <= n_s2_ctl;
            if (i_accept) begin
                r_rd_vld <= r_line_vld[cur_col[LAW-1:0]];
            end
            if (r_s1_vld) begin
                r_line_vld[r_s1_col[LAW-1:0]] <= 1'b1;
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col    <= cur_col;
            r_s1_row    <= cur_row;
            r_s1_sample <= i_sample;
        end
        r_s2_idx <= n_s2_idx;
    end

    assign o_ctl = r_s2_ctl;
    assign o_idx = r_s2_idx;
    assign o_win = r_win;

    a_s1_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |=> r_s2_ctl.vld)
        else $error("window stage lost a word");

    a_last_is_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_ctl.last_px |-> (r_s2_ctl.emit && r_s2_ctl.vld))
        else $error("plane end flagged on a border word");

endmodule

/* rtl/cnv3_mac.sv */
// cnv3_mac: nine products, dot product, accumulator RAM read-modify-write, bias and clamp.
// Depends on cnv3_pkg.

module cnv3_mac #(
    parameter int MAX_WIDTH   = cnv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = cnv3_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = cnv3_pkg::DEF_SAMPLE_BITS,
    parameter int AW          = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cnv3_pkg::t_cfg                i_cfg,
    input  cnv3_pkg::t_pipe_ctl           i_ctl,
    input  logic [AW-1:0]                 i_idx,
    input  logic signed [SAMPLE_BITS-1:0] i_win [cnv3_pkg::KERNEL*cnv3_pkg::KERNEL],
    output logic                          o_push,
    output cnv3_pkg::t_result             o_result,
    output logic                          o_retire
);
    import cnv3_pkg::*;

    localparam int KK    = KERNEL * KERNEL;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PW    = SAMPLE_BITS + WEIGHT_W;   // one product
    localparam int RSW   = PW + 2;                   // sum of one kernel row
    localparam int DW    = PW + 4;                   // full dot product
    localparam int SW    = ((DW > ACC_W) ? DW : ACC_W) + 1;
    localparam int BW    = ACC_W + 1;

    // stage 3: products
    t_pipe_ctl             r_s3_ctl;
    logic [AW-1:0]         r_s3_idx;
    logic signed [PW-1:0]  r_prod [KK];
    logic signed [PW-1:0]  n_prod [KK];

    always_comb begin
        for (int r = 0; r < KERNEL; r++) begin
            for (int c = 0; c < KERNEL; c++) begin
                n_prod[r*KERNEL + c] = PW'(i_win[r*KERNEL + c]) * PW'(weight_at(i_cfg, r, c));
            end
        end
    end

    // stage 4: row sums, accumulator read
    t_pipe_ctl             r_s4_ctl;
    logic [AW-1:0]         r_s4_idx;
    logic signed [RSW-1:0] r_rsum [KERNEL];
    logic signed [RSW-1:0] n_rsum [KERNEL];
    logic signed [ACC_W-1:0] r_acc_mem [DEPTH];
    logic signed [ACC_W-1:0] r_acc_rd;

    always_comb begin
        for (int r = 0; r < KERNEL; r++) begin
            n_rsum[r] = RSW'(r_prod[r*KERNEL]) + RSW'(r_prod[r*KERNEL + 1])
                        + RSW'(r_prod[r*KERNEL + 2]);
        end
    end

    // stage 5: accumulate and clamp to the accumulator range
    t_pipe_ctl               r_s5_ctl;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [DW-1:0]    dot;
    logic signed [SW-1:0]    acc_sum;
    logic signed [SW-1:0]    acc_hi, acc_lo;

    always_comb begin
        acc_hi = SW'($signed({1'b0, {(ACC_W-1){1'b1}}}));
        acc_lo = SW'($signed({1'b1, {(ACC_W-1){1'b0}}}));
        dot    = DW'(r_rsum[0]) + DW'(r_rsum[1]) + DW'(r_rsum[2]);
        if (i_cfg.first_channel) begin
            acc_sum = SW'(dot);
        end else begin
            acc_sum = SW'(r_acc_rd) + SW'(dot);
        end
        if (acc_sum > acc_hi) begin
            n_acc = acc_hi[ACC_W-1:0];
        end else if (acc_sum < acc_lo) begin
            n_acc = acc_lo[ACC_W-1:0];
        end else begin
            n_acc = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_rd <= r_acc_mem[r_s3_idx];
        if (r_s4_ctl.vld && r_s4_ctl.emit) begin
            r_acc_mem[r_s4_idx] <= n_acc;
        end
    end

    // output: bias, clamp to 32 bits
    logic signed [BW-1:0] res_sum, res_hi, res_lo;

    always_comb begin
        res_hi  = BW'($signed({1'b0, {(RES_W-1){1'b1}}}));
        res_lo  = BW'($signed({1'b1, {(RES_W-1){1'b0}}}));
        res_sum = BW'(r_acc) + BW'(i_cfg.bias_value);
        if (res_sum > res_hi) begin
            o_result.value = res_hi[RES_W-1:0];
        end else if (res_sum < res_lo) begin
            o_result.value = res_lo[RES_W-1:0];
        end else begin
            o_result.value = res_sum[RES_W-1:0];
        end
        o_result.plane_done = r_s5_ctl.last_px;
        o_push   = r_s5_ctl.vld && r_s5_ctl.emit && i_cfg.last_channel;
        o_retire = r_s5_ctl.vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
            r_s5_ctl <= '0;
        end else begin
            r_s3_ctl <= i_ctl;
            r_s4_ctl <= r_s3_ctl;
            r_s5_ctl <= r_s4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_idx <= i_idx;
        r_s4_idx <= r_s3_idx;
        r_prod   <= n_prod;
        r_rsum   <= n_rsum;
        r_acc    <= n_acc;
    end

endmodule

/* rtl/cnv3_out_fifo.sv */
// cnv3_out_fifo: small result queue that drives the output channel.
// Depends on cnv3_pkg and cnv3_result_if.

module cnv3_out_fifo (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    input  cnv3_pkg::t_result                         i_result,
    output logic [$clog2(cnv3_pkg::FIFO_DEPTH+1)-1:0] o_count,
    cnv3_result_if.source                             o_result_ch
);
    import cnv3_pkg::*;

    localparam int PTRW = $clog2(FIFO_DEPTH);
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTRW-1:0]  r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             pop;

    assign pop                      = o_result_ch.valid && o_result_ch.ready;
    assign o_result_ch.valid        = (r_cnt != '0);
    assign o_result_ch.result_value = r_mem[r_rp].value;
    assign o_result_ch.plane_done   = r_mem[r_rp].plane_done;
    assign o_count                  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTRW'(FIFO_DEPTH - 1)) ? '0 : r_wp + PTRW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTRW'(FIFO_DEPTH - 1)) ? '0 : r_rp + PTRW'(1);
            end
            r_cnt <= r_cnt + CNTW'(i_push) - CNTW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < CNTW'(FIFO_DEPTH)))
        else $error("result queue written while full");

endmodule

/* rtl/conv3x3_same_channel_accumulate.sv */
// conv3x3_same_channel_accumulate: top level of the 3x3 same-padded convolution block.
// Depends on cnv3_pkg, the cnv3 channel interfaces, cnv3_cfg_regs, cnv3_window,
// cnv3_mac and cnv3_out_fifo.
//
//  channel       dir  handshake     payload
//  i_cfg_ch      in   valid/ready   index (3b), data (48b)
//  i_sample_ch   in   valid/ready   sample (SAMPLE_BITS, signed Q8.8)
//  o_result_ch   out  valid/ready   result_value (32b signed Q16.16), plane_done
//
// One sample word per clock while i_sample_ch.ready is high. A result passes the window
// shift, the accumulator RAM port (read, then write in the next cycle) and the bias clamp,
// is written into the result queue and is offered on o_result_ch from then on.
// Synchronous active-low reset clears counters, window, line-store valid bits and
// registers; accumulator RAM is not cleared (first_channel overwrites it).
// Stalls: an 8-word result queue; i_sample_ch.ready drops once words in flight plus
// queued words reach 8, so nothing is lost when o_result_ch is held off.

module conv3x3_same_channel_accumulate #(
    parameter int MAX_WIDTH   = cnv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = cnv3_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = cnv3_pkg::DEF_SAMPLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cnv3_cfg_if.sink      i_cfg_ch,
    cnv3_sample_if.sink   i_sample_ch,
    cnv3_result_if.source o_result_ch
);
    import cnv3_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int KK   = KERNEL * KERNEL;
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);
    localparam int CRW  = CNTW + 1;

    t_cfg                          cfg;
    t_pipe_ctl                     win_ctl;
    logic [AW-1:0]                 win_idx;
    logic signed [SAMPLE_BITS-1:0] win [KK];
    logic                          push, retire, accept;
    t_result                       result;
    logic [CNTW-1:0]               fifo_cnt;
    logic [CNTW-1:0]               r_inflight, n_inflight;
    logic [CRW-1:0]                credit_used;

    // credit: every word in the pipeline may still need a queue slot
    assign credit_used       = {1'b0, r_inflight} + {1'b0, fifo_cnt};
    assign i_sample_ch.ready = (credit_used < CRW'(FIFO_DEPTH));
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;
    assign n_inflight        = r_inflight + CNTW'(accept) - CNTW'(retire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    cnv3_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_cfg    (cfg)
    );

    cnv3_window #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_sample (i_sample_ch.sample),
        .o_ctl    (win_ctl),
        .o_idx    (win_idx),
        .o_win    (win)
    );

    cnv3_mac #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_ctl    (win_ctl),
        .i_idx    (win_idx),
        .i_win    (win),
        .o_push   (push),
        .o_result (result),
        .o_retire (retire)
    );

    cnv3_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (result),
        .o_count     (fifo_cnt),
        .o_result_ch (o_result_ch)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit_used <= CRW'(FIFO_DEPTH))
        else $error("words in flight exceed queue space");

    a_accept_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_inflight != '0))
        else $error("accepted word not counted in flight");

endmodule

/* test/tb_conv3x3_same_channel_accumulate.sv */
`timescale 1ns / 100ps
// tb_conv3x3_same_channel_accumulate: self-checking bench for the 3x3 same-padded convolution,
// an in-bench predictor of window, line store and accumulators, random valid/ready pacing.
// Depends on cnv3_pkg, the cnv3 channel interfaces and conv3x3_same_channel_accumulate.

module tb_conv3x3_same_channel_accumulate;
    import cnv3_pkg::*;

    localparam int MAXW     = DEF_MAX_WIDTH;
    localparam int MAXH     = DEF_MAX_HEIGHT;
    localparam int SMP_W    = DEF_SAMPLE_BITS;
    localparam int LINE_LEN = MAXW + 2;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));
    localparam longint RES_HI = (longint'(1) <<< (RES_W - 1)) - 1;
    localparam longint RES_LO = -(longint'(1) <<< (RES_W - 1));

    localparam int SETTLE      = 12;      // covers the pipeline depth, leaves margin
    localparam int MAX_PRINT   = 100;
    localparam int SAT_PLANES  = 60;      // 57 planes of full-scale products pass the 40-bit limit
    localparam int BACK_PLANES = 57;      // brings a clipped accumulator back into 32-bit range
    localparam int TIMEOUT_NS  = 5_000_000;

    localparam logic [SMP_W-1:0] EDGE_SMP [9] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000,
        16'h7FFF, 16'h0001, 16'h8000, 16'h8000
    };

    logic i_clk;
    logic i_rst_n;

    cnv3_sample_if #(.SAMPLE_BITS(SMP_W)) smp_ch ();
    cnv3_result_if                        res_ch ();
    cnv3_cfg_if                           cfg_ch ();

    conv3x3_same_channel_accumulate #(
        .MAX_WIDTH   (MAXW),
        .MAX_HEIGHT  (MAXH),
        .SAMPLE_BITS (SMP_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_ch    (cfg_ch),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch)
    );

    // predictor state
    t_cfg                    conv_cfg;
    logic signed [SMP_W-1:0] line_buf [2][LINE_LEN];
    logic signed [SMP_W-1:0] win [3][3];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic signed [ACC_W-1:0] acc_mem [MAXW*MAXH];

    logic [SMP_W-1:0] sample_queue [$];   // words waiting to be sent
    t_result          result_queue [$];   // predicted results, oldest first

    bit sample_taken;
    bit gaps_on;
    int tx_gap;
    int rx_gap;
    int rx_hold;
    int items_sent;
    int fail_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advances the predicted window by one sample word; returns 1 when a result is due.
    function automatic bit conv_step(input logic signed [SMP_W-1:0] smp, output t_result res);
        int unsigned       w, h, col, row, idx;
        int                r, c;
        logic [WROW_W-1:0] wrow;
        longint            dot, acc, biased;
        w = eff_dim(conv_cfg.image_width, MAXW);
        h = eff_dim(conv_cfg.image_height, MAXH);
        res = '0;
        conv_step = 1'b0;
        // size may have shrunk under the counters
        if (col_pos >= w + 2)
            col_pos = 0;
        if (row_pos >= h + 2)
            row_pos = 0;
        col = col_pos;
        row = row_pos;
        for (r = 0; r < KERNEL; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = line_buf[0][col];
        win[1][2] = line_buf[1][col];
        win[2][2] = smp;
        line_buf[0][col] = line_buf[1][col];
        line_buf[1][col] = smp;
        if (row >= 2 && col >= 2) begin
            idx = (row - 2) * MAXW + (col - 2);
            dot = 0;
            for (r = 0; r < KERNEL; r++) begin
                wrow = (r == 0) ? conv_cfg.weights_top :
                       (r == 1) ? conv_cfg.weights_middle : conv_cfg.weights_bottom;
                for (c = 0; c < KERNEL; c++)
                    dot += longint'($signed(wrow[WEIGHT_W*c +: WEIGHT_W])) * longint'(win[r][c]);
            end
            acc = conv_cfg.first_channel ? dot : longint'(acc_mem[idx]) + dot;
            acc = clamp(acc, ACC_LO, ACC_HI);
            acc_mem[idx] = acc[ACC_W-1:0];
            if (conv_cfg.last_channel) begin
                biased = clamp(acc + longint'($signed(conv_cfg.bias_value)), RES_LO, RES_HI);
                res.value = biased[RES_W-1:0];
                res.plane_done = (row == h + 1) && (col == w + 1);
                conv_step = 1'b1;
            end
        end
        col_pos = col + 1;
        if (col_pos >= w + 2) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h + 2)
                row_pos = 0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINT)
            $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Unused upper data bits carry noise; the register takes only its own field.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        int                    fw;
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] d;
        case (idx)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT:   fw = DIM_W;
            REG_BIAS_VALUE:                      fw = BIAS_W;
            REG_FIRST_CHANNEL, REG_LAST_CHANNEL: fw = 1;
            default:                             fw = WROW_W;
        endcase
        keep = (fw >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << fw) - 1);
        d = (value & keep) | (CFG_DATA_W'({$urandom, $urandom}) & ~keep);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_IMAGE_WIDTH:    conv_cfg.image_width    = d[DIM_W-1:0];
            REG_IMAGE_HEIGHT:   conv_cfg.image_height   = d[DIM_W-1:0];
            REG_WEIGHTS_TOP:    conv_cfg.weights_top    = d[WROW_W-1:0];
            REG_WEIGHTS_MIDDLE: conv_cfg.weights_middle = d[WROW_W-1:0];
            REG_WEIGHTS_BOTTOM: conv_cfg.weights_bottom = d[WROW_W-1:0];
            REG_BIAS_VALUE:     conv_cfg.bias_value     = d[BIAS_W-1:0];
            REG_FIRST_CHANNEL:  conv_cfg.first_channel  = d[0];
            REG_LAST_CHANNEL:   conv_cfg.last_channel   = d[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_kernel(input logic [WROW_W-1:0] top, input logic [WROW_W-1:0] mid,
                                input logic [WROW_W-1:0] bot);
        write_reg(REG_WEIGHTS_TOP, top);
        write_reg(REG_WEIGHTS_MIDDLE, mid);
        write_reg(REG_WEIGHTS_BOTTOM, bot);
    endtask

    task automatic push_plane(input int n);
        repeat (n) sample_queue.push_back(pick16());
        items_sent += n;
    endtask

    // Waits until every word is taken and every predicted result has come back.
    task automatic wait_idle();
        while (sample_queue.size() != 0 || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One filter pass over nch channel planes of one size.
    task automatic run_filter(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input int nch, input bit pause_mid, input int hold);
        int n;
        int ch;
        n = (eff_dim(w, MAXW) + 2) * (eff_dim(h, MAXH) + 2);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_BIAS_VALUE, {pick16(), pick16()});
        write_reg(REG_FIRST_CHANNEL, 1);
        write_reg(REG_LAST_CHANNEL, nch == 1);
        for (ch = 0; ch < nch; ch++) begin
            if (ch > 0) begin
                wait_idle();
                if (ch == 1)
                    write_reg(REG_FIRST_CHANNEL, 0);
                if (ch == nch - 1)
                    write_reg(REG_LAST_CHANNEL, 1);
            end
            if (ch == 0 || $urandom_range(0, 1))
                write_kernel({pick16(), pick16(), pick16()}, {pick16(), pick16(), pick16()},
                             {pick16(), pick16(), pick16()});
            if (ch == nch - 1)
                rx_hold = hold;
            if (pause_mid) begin
                push_plane(n / 2);
                wait_idle();
                push_plane(n - n / 2);
            end else begin
                push_plane(n);
            end
        end
        wait_idle();
    endtask

    // 1x1 planes of full-scale products drive the accumulator into its clip, then back.
    task automatic acc_clip_round_trip();
        logic [WEIGHT_W-1:0] w_up;
        logic [WEIGHT_W-1:0] w_back;
        int                  k;
        // every sample sits at the negative limit, so the weight sets the product's sign
        if ($urandom_range(0, 1)) begin
            w_up   = 16'h8000;
            w_back = 16'h7FFF;
        end else begin
            w_up   = 16'h7FFF;
            w_back = 16'h8000;
        end
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_BIAS_VALUE, 0);
        write_reg(REG_FIRST_CHANNEL, 1);
        write_reg(REG_LAST_CHANNEL, 1);
        write_kernel({3{w_up}}, {3{w_up}}, {3{w_up}});
        for (k = 0; k < SAT_PLANES + BACK_PLANES; k++) begin
            if (k == 1) begin
                wait_idle();
                write_reg(REG_FIRST_CHANNEL, 0);
            end
            if (k == SAT_PLANES) begin
                wait_idle();
                write_kernel({3{w_back}}, {3{w_back}}, {3{w_back}});
            end
            repeat (9) sample_queue.push_back(16'h8000);
            items_sent += 9;
        end
        wait_idle();
    endtask

    // sample word driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
        end else if (!smp_ch.valid || sample_taken) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                smp_ch.valid <= 1'b0;
            end else if (sample_queue.size() == 0) begin
                smp_ch.valid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                tx_gap = $urandom_range(0, 8);
                smp_ch.valid <= 1'b0;
            end else begin
                smp_ch.valid  <= 1'b1;
                smp_ch.sample <= sample_queue[0];
            end
        end
    end

    // result ready, with the long hold-off counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            res_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            res_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 8);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // result check first, then prediction of the word taken at this edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (result_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d, plane_done %0b",
                                              res_ch.result_value, res_ch.plane_done));
                end else begin
                    want = result_queue.pop_front();
                    if (res_ch.result_value !== want.value)
                        report_mismatch($sformatf("result_value got %0d, want %0d",
                                                  res_ch.result_value, want.value));
                    if (res_ch.plane_done !== want.plane_done)
                        report_mismatch($sformatf("plane_done got %0b, want %0b",
                                                  res_ch.plane_done, want.plane_done));
                end
            end
            sample_taken <= smp_ch.valid && smp_ch.ready;
            if (smp_ch.valid && smp_ch.ready) begin
                void'(sample_queue.pop_front());
                if (conv_step(smp_ch.sample, got))
                    result_queue.push_back(got);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        gaps_on       = 1'b1;
        conv_cfg = '{image_width: 8'd128, image_height: 8'd128, weights_top: '0,
                     weights_middle: '0, weights_bottom: '0, bias_value: '0,
                     first_channel: 1'b1, last_channel: 1'b1};
        foreach (line_buf[i, j])
            line_buf[i][j] = '0;
        foreach (win[i, j])
            win[i][j] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one 1x1 plane of edge-case samples and weights, bias at its top
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_kernel(48'h7FFF_8000_0001, 48'hFFFF_0000_7FFF, 48'h8000_8000_8000);
        write_reg(REG_BIAS_VALUE, 48'h7FFF_FFFF);
        write_reg(REG_FIRST_CHANNEL, 1);
        write_reg(REG_LAST_CHANNEL, 1);
        foreach (EDGE_SMP[k])
            sample_queue.push_back(EDGE_SMP[k]);
        items_sent += 9;
        wait_idle();

        // cut a 2x2 plane short with both counters past the new 1x1 bound
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_BIAS_VALUE, 48'h8000_0000);
        push_plane(15);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        push_plane(9);
        wait_idle();

        run_filter(8, 8, 1, 1'b0, 200);     // output held off until the input backs up
        run_filter(5, 4, 2, 1'b1, 0);       // sender stops mid-plane until drained
        while (items_sent < 300) begin
            gaps_on = $urandom_range(0, 3) != 0;
            run_filter($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(1, 3),
                       $urandom_range(0, 5) == 0, 0);
        end
        gaps_on = 1'b1;
        run_filter(128, 0, 1, 1'b0, 0);     // widest row, height below range
        run_filter(0, 255, 1, 1'b0, 0);     // width below range, height above
        acc_clip_round_trip();

        gaps_on = 1'b0;
        repeat (3)
            run_filter($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 3),
                       1'b0, 0);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

/* conv3x3_same_channel_accumulate.f */
rtl/cnv3_pkg.sv
rtl/cnv3_chan_if.sv
rtl/cnv3_cfg_regs.sv
rtl/cnv3_window.sv
rtl/cnv3_mac.sv
rtl/cnv3_out_fifo.sv
rtl/conv3x3_same_channel_accumulate.sv
test/tb_conv3x3_same_channel_accumulate.sv
